// ===== design/dsc_pkg.sv =====
package dsc_pkg;

    localparam int RESIDUE_SLOTS = 65536;
    localparam int RES_W         = $clog2(RESIDUE_SLOTS);
    localparam int EDIV_W        = RES_W + 1;
    localparam int ELEM_W        = 30;
    localparam int DIV_W         = 17;
    localparam int CNT_W         = 32;
    localparam int TOT_W         = 64;
    localparam int EPOCH_W       = 8;
    localparam int DVD_W         = ((ELEM_W > RES_W) ? ELEM_W : RES_W) + 1;
    localparam int STEP_W        = $clog2(DVD_W + 1);
    localparam int S_TDATA_W     = ((ELEM_W + 7) / 8) * 8;
    localparam int M_TDATA_W     = TOT_W;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam logic [PADDR_W-3:0] REG_DIVISOR   = '0;
    localparam logic [DIV_W-1:0]   DIVISOR_RESET = DIV_W'(1);

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic [EPOCH_W-1:0] epoch;
        logic [CNT_W-1:0]   count;
    } slot_t;

endpackage

// ===== design/dsc_rem_unit.sv =====
module dsc_rem_unit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [dsc_pkg::DVD_W-1:0]  dividend,
    input  logic [dsc_pkg::EDIV_W-1:0] divisor,
    output dsc_pkg::div_stat_t         stat,
    output logic [dsc_pkg::RES_W-1:0]  rem
);
    import dsc_pkg::*;

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DVD_W-1:0]  dvd_reg;
    logic [RES_W-1:0]  rem_reg;
    logic [EDIV_W-1:0] dsr_reg;
    logic [EDIV_W-1:0] trial;
    logic [EDIV_W-1:0] rem_next;

    // one quotient bit per cycle, restoring form
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[DVD_W-1]};
        rem_next = (trial >= dsr_reg) ? (trial - dsr_reg) : trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= STEP_W'(DVD_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dvd_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            dvd_reg <= {dvd_reg[DVD_W-2:0], 1'b0};
            rem_reg <= rem_next[RES_W-1:0];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign rem       = rem_reg;

endmodule

// ===== design/divisible_subarray_counter_top.sv =====
// items are taken one at a time; each passes the 31-step remainder unit and
//   the read-modify-write of the residue count memory before the next is taken;
//   after a last item the total is registered out once the output is free
// reset: asynchronous, active low; divisor returns to 1 and a clearing pass
//   sweeps the count memory before the first item is taken
// the same pass repeats after every 255th sequence when the epoch wraps
module divisible_subarray_counter_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [dsc_pkg::S_TDATA_W-1:0]  s_tdata,   // element_value, zero pad
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [dsc_pkg::M_TDATA_W-1:0]  m_tdata,   // pair_total
    output logic                           m_tuser,   // saturated
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsc_pkg::PADDR_W-1:0]    paddr,
    input  logic [dsc_pkg::PDATA_W-1:0]    pwdata,
    output logic [dsc_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);
    import dsc_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_UPD   = 3'd4;
    localparam logic [2:0] ST_EMIT  = 3'd5;

    logic [2:0]         state_reg;
    logic [DIV_W-1:0]   divisor_reg;
    logic [RES_W-1:0]   residue_reg;
    logic [TOT_W-1:0]   total_reg;
    logic               ovf_reg;
    logic [EPOCH_W-1:0] epoch_reg;
    logic [RES_W-1:0]   clr_reg;
    logic               last_reg;
    logic               m_tvalid_reg;
    logic [TOT_W-1:0]   out_total_reg;
    logic               out_sat_reg;

    slot_t              mem [RESIDUE_SLOTS];
    slot_t              rd_data_reg;
    logic               mem_we;
    logic [RES_W-1:0]   mem_waddr;
    slot_t              mem_wdata;

    logic               cfg_wr;
    logic [EDIV_W-1:0]  eff_div;
    logic               accept;
    logic               out_free;
    logic               div_start;
    logic [DVD_W-1:0]   dividend;
    div_stat_t          div_stat;
    logic [RES_W-1:0]   div_rem;

    logic [CNT_W-1:0]   cur_count;
    logic [CNT_W:0]     earlier;
    logic [TOT_W:0]     sum;
    logic [TOT_W-1:0]   total_next;
    logic               ovf_next;
    logic [CNT_W-1:0]   count_next;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready
                    && (paddr[PADDR_W-1:2] == REG_DIVISOR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divisor_reg <= DIVISOR_RESET;
        end
        else if (cfg_wr)
        begin
            divisor_reg <= pwdata[DIV_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1:2] == REG_DIVISOR)
                    ? {(PDATA_W - DIV_W)'(0), divisor_reg} : '0;

    // divisor clamped to 1..RESIDUE_SLOTS
    always_comb
    begin
        if (divisor_reg == '0)
        begin
            eff_div = EDIV_W'(1);
        end
        else if (32'(divisor_reg) > 32'(RESIDUE_SLOTS))
        begin
            eff_div = EDIV_W'(RESIDUE_SLOTS);
        end
        else
        begin
            eff_div = EDIV_W'(divisor_reg);
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign div_start = accept;
    assign dividend  = DVD_W'(s_tdata[ELEM_W-1:0]) + DVD_W'(residue_reg);

    dsc_rem_unit u_rem (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (eff_div),
        .stat     (div_stat),
        .rem      (div_rem)
    );

    // count update; stale epochs read as zero
    always_comb
    begin
        cur_count  = (rd_data_reg.epoch == epoch_reg) ? rd_data_reg.count : '0;
        earlier    = {1'b0, cur_count} + ((residue_reg == '0) ? (CNT_W+1)'(1) : '0);
        sum        = {1'b0, total_reg} + (TOT_W+1)'(earlier);
        total_next = sum[TOT_W] ? '1 : sum[TOT_W-1:0];
        ovf_next   = ovf_reg || (total_next == '1);
        count_next = (cur_count == '1) ? cur_count : cur_count + CNT_W'(1);
    end

    always_comb
    begin
        mem_we          = 1'b0;
        mem_waddr       = residue_reg;
        mem_wdata.epoch = epoch_reg;
        mem_wdata.count = count_next;
        case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
            end
            ST_UPD:
            begin
                mem_we = 1'b1;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (state_reg == ST_READ)
        begin
            rd_data_reg <= mem[residue_reg];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            residue_reg  <= '0;
            total_reg    <= '0;
            ovf_reg      <= 1'b0;
            epoch_reg    <= EPOCH_W'(1);
            clr_reg      <= '0;
            last_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (m_tready && !(state_reg == ST_EMIT && out_free))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_reg <= clr_reg + RES_W'(1);
                    if (clr_reg == '1)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg  <= s_tlast;
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    if (div_stat.done)
                    begin
                        residue_reg <= div_rem;
                        state_reg   <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_UPD;
                end
                ST_UPD:
                begin
                    total_reg <= total_next;
                    ovf_reg   <= ovf_next;
                    state_reg <= last_reg ? ST_EMIT : ST_IDLE;
                end
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        residue_reg  <= '0;
                        total_reg    <= '0;
                        ovf_reg      <= 1'b0;
                        if (epoch_reg == '1)
                        begin
                            epoch_reg <= EPOCH_W'(1);
                            clr_reg   <= '0;
                            state_reg <= ST_CLEAR;
                        end
                        else
                        begin
                            epoch_reg <= epoch_reg + EPOCH_W'(1);
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_EMIT && out_free)
        begin
            out_total_reg <= total_reg;
            out_sat_reg   <= ovf_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_total_reg;
    assign m_tuser  = out_sat_reg;

endmodule

// ===== design/dsc_checker.sv =====
module dsc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [dsc_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic                           m_tuser,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dsc_pkg::PADDR_W-1:0]    paddr,
    input  logic [dsc_pkg::PDATA_W-1:0]    pwdata,
    input  logic [dsc_pkg::PDATA_W-1:0]    prdata
);
    import dsc_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // one item at a time
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted while busy");

    // saturated flag matches a maxed total
    a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser == (m_tdata == '1)))
        else $error("saturated flag disagrees with total");

    // divisor readback
    a_cfg_read: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && (paddr[PADDR_W-1:2] == REG_DIVISOR)
        |=> prdata == {(PDATA_W - DIV_W)'(0), $past(pwdata[DIV_W-1:0])})
        else $error("divisor readback mismatch");

endmodule

bind divisible_subarray_counter_top dsc_checker u_dsc_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
